### design/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg: shared constants for the RESP2 request parser
// Byte codes, parse phases, error codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rrp_pkg;

   // default sizes and reset values
   localparam int DEF_LENGTH_BITS = 31;
   localparam int DEF_COUNT_BITS  = 8;
   localparam logic [7:0] MAX_ARGS_RESET = 8'd64;

   // framing bytes
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // parse phases
   localparam logic [3:0] PH_STAR    = 4'd0;
   localparam logic [3:0] PH_CNT_DIG = 4'd1;
   localparam logic [3:0] PH_CNT_LF  = 4'd2;
   localparam logic [3:0] PH_DOLLAR  = 4'd3;
   localparam logic [3:0] PH_LEN_DIG = 4'd4;
   localparam logic [3:0] PH_LEN_LF  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_PAY_CR  = 4'd7;
   localparam logic [3:0] PH_PAY_LF  = 4'd8;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_PREFIX = 3'd1;
   localparam logic [2:0] ERR_BAD_DIGIT  = 3'd2;
   localparam logic [2:0] ERR_NO_DIGITS  = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd4;
   localparam logic [2:0] ERR_BAD_COUNT  = 3'd5;
   localparam logic [2:0] ERR_BAD_CRLF   = 3'd6;

endpackage

`default_nettype wire

### design/resp_request_parser_core.sv
// ----------------------------------------------------------------------------
// resp_request_parser_core: streaming RESP2 array command parser
// Classifies each request byte as framing or payload and tracks argument
// index, length and count; flags malformed input and drops back to '*'.
// ----------------------------------------------------------------------------
// Path: a request byte passes the input register, then the result register.
// Throughput: one request byte per cycle unless rsp_stall holds the result;
// the phase machine settles each byte combinationally between the two registers.
// Reset: clears both valids and all parse state, max_args returns to 64.
// No clearing pass; the block accepts requests right after reset.
`default_nettype none

module resp_request_parser_core
   import rrp_pkg::*;
#(
   parameter int LENGTH_BITS = DEF_LENGTH_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [7:0]             csr_write_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_in_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_byte_value,
   output logic                        rsp_is_payload,
   output logic [7:0]                  rsp_arg_index,
   output logic [LENGTH_BITS-1:0]      rsp_arg_length,
   output logic [7:0]                  rsp_arg_count,
   output logic                        rsp_arg_done,
   output logic                        rsp_command_done,
   output logic                        rsp_error_flag,
   output logic [2:0]                  rsp_error_code
);

   localparam logic [LENGTH_BITS-1:0] NUM_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] NUM_DIV10 = LENGTH_BITS'(NUM_MAX / 10);
   localparam logic [3:0] NUM_MOD10 = 4'(NUM_MAX % 10);
   localparam logic [LENGTH_BITS+15:0] CNT_MAX_EXT =
      (LENGTH_BITS+16)'((1 << COUNT_BITS) - 1);

   // configuration
   logic [7:0] max_args_ff;

   // input stage
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_adv;

   // parse state
   logic [3:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] accum_ff, accum_in;
   logic                   seen_ff, seen_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  index_ff, index_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;

   // result register
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_byte_ff;
   logic                   rsp_payload_ff, rsp_payload_in;
   logic [7:0]             rsp_index_ff, rsp_index_in;
   logic [LENGTH_BITS-1:0] rsp_length_ff, rsp_length_in;
   logic [7:0]             rsp_count_ff, rsp_count_in;
   logic                   rsp_adone_ff, rsp_adone_in;
   logic                   rsp_cdone_ff, rsp_cdone_in;
   logic [2:0]             rsp_err_ff, rsp_err_in;

   // number line helpers
   logic                   is_digit;
   logic [3:0]             digit;
   logic                   num_ovf;
   logic [LENGTH_BITS+3:0] acc_mul;
   logic [LENGTH_BITS+15:0] acc_ext;
   logic [LENGTH_BITS-1:0] left_dec;
   logic [COUNT_BITS-1:0]  index_inc;
   logic [COUNT_BITS-1:0]  o_idx, o_cnt;
   logic [LENGTH_BITS-1:0] o_len;
   logic [COUNT_BITS+7:0]  o_idx_ext, o_cnt_ext;
   logic [7:0]             b;

   assign s1_adv    = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_adv;

   assign b        = s1_byte_ff;
   assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign digit    = 4'(b - CHAR_ZERO);
   assign num_ovf  = (accum_ff > NUM_DIV10) ||
                     ((accum_ff == NUM_DIV10) && (digit > NUM_MOD10));
   // times ten as two shifts, then add the digit
   assign acc_mul  = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) +
                     {LENGTH_BITS'(0), digit};
   assign acc_ext  = {16'b0, accum_ff};
   assign left_dec = (left_ff != '0) ? left_ff - LENGTH_BITS'(1) : left_ff;
   assign index_inc = index_ff + COUNT_BITS'(1);

   always_comb begin
      phase_in       = phase_ff;
      accum_in       = accum_ff;
      seen_in        = seen_ff;
      count_in       = count_ff;
      index_in       = index_ff;
      length_in      = length_ff;
      left_in        = left_ff;
      rsp_err_in     = ERR_NONE;
      rsp_payload_in = 1'b0;
      rsp_adone_in   = 1'b0;
      rsp_cdone_in   = 1'b0;
      o_idx          = index_ff;
      o_len          = length_ff;
      o_cnt          = count_ff;

      unique case (phase_ff)
         PH_STAR: begin
            if (b == CHAR_STAR) begin
               phase_in = PH_CNT_DIG;
               accum_in = '0;
               seen_in  = 1'b0;
            end else begin
               rsp_err_in = ERR_BAD_PREFIX;
            end
         end
         PH_CNT_DIG, PH_LEN_DIG: begin
            if (b == CHAR_CR) begin
               if (!seen_ff) begin
                  rsp_err_in = ERR_NO_DIGITS;
               end else begin
                  phase_in = (phase_ff == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
               end
            end else if (!is_digit) begin
               rsp_err_in = ERR_BAD_DIGIT;
            end else if (num_ovf) begin
               rsp_err_in = ERR_OVERFLOW;
            end else begin
               accum_in = acc_mul[LENGTH_BITS-1:0];
               seen_in  = 1'b1;
            end
         end
         PH_CNT_LF: begin
            if (b != CHAR_LF) begin
               rsp_err_in = ERR_BAD_CRLF;
            end else if (accum_ff == '0 || accum_ff > LENGTH_BITS'(max_args_ff) ||
                         acc_ext > CNT_MAX_EXT) begin
               rsp_err_in = ERR_BAD_COUNT;
            end else begin
               count_in = acc_ext[COUNT_BITS-1:0];
               index_in = '0;
               o_cnt    = acc_ext[COUNT_BITS-1:0];
               o_idx    = '0;
               phase_in = PH_DOLLAR;
            end
         end
         PH_DOLLAR: begin
            if (b == CHAR_DOLLAR) begin
               length_in = '0;
               o_len     = '0;
               accum_in  = '0;
               seen_in   = 1'b0;
               phase_in  = PH_LEN_DIG;
            end else begin
               rsp_err_in = ERR_BAD_PREFIX;
            end
         end
         PH_LEN_LF: begin
            if (b != CHAR_LF) begin
               rsp_err_in = ERR_BAD_CRLF;
            end else begin
               length_in = accum_ff;
               left_in   = accum_ff;
               o_len     = accum_ff;
               phase_in  = (accum_ff != '0) ? PH_PAYLOAD : PH_PAY_CR;
            end
         end
         PH_PAYLOAD: begin
            rsp_payload_in = 1'b1;
            left_in        = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_PAY_CR;
            end
         end
         PH_PAY_CR: begin
            if (b == CHAR_CR) begin
               phase_in = PH_PAY_LF;
            end else begin
               rsp_err_in = ERR_BAD_CRLF;
            end
         end
         PH_PAY_LF: begin
            if (b != CHAR_LF) begin
               rsp_err_in = ERR_BAD_CRLF;
            end else begin
               rsp_adone_in = 1'b1;
               if (index_inc >= count_ff) begin
                  // last argument: command complete, start over
                  rsp_cdone_in = 1'b1;
                  phase_in     = PH_STAR;
                  accum_in     = '0;
                  seen_in      = 1'b0;
                  count_in     = '0;
                  index_in     = '0;
                  length_in    = '0;
                  left_in      = '0;
               end else begin
                  index_in = index_inc;
                  phase_in = PH_DOLLAR;
               end
            end
         end
         default: begin
            phase_in  = PH_STAR;
            accum_in  = '0;
            seen_in   = 1'b0;
            count_in  = '0;
            index_in  = '0;
            length_in = '0;
            left_in   = '0;
         end
      endcase

      // drop the partial command on any error
      if (rsp_err_in != ERR_NONE) begin
         phase_in  = PH_STAR;
         accum_in  = '0;
         seen_in   = 1'b0;
         count_in  = '0;
         index_in  = '0;
         length_in = '0;
         left_in   = '0;
         o_idx     = '0;
         o_len     = '0;
         o_cnt     = '0;
      end

      o_idx_ext     = {8'b0, o_idx};
      o_cnt_ext     = {8'b0, o_cnt};
      rsp_index_in  = o_idx_ext[7:0];
      rsp_count_in  = o_cnt_ext[7:0];
      rsp_length_in = o_len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= MAX_ARGS_RESET;
      end else if (csr_write_en) begin
         max_args_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_in_byte;
      end
   end

   // parse state advances as the byte moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STAR;
         accum_ff  <= '0;
         seen_ff   <= 1'b0;
         count_ff  <= '0;
         index_ff  <= '0;
         length_ff <= '0;
         left_ff   <= '0;
      end else if (s1_adv) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         seen_ff   <= seen_in;
         count_ff  <= count_in;
         index_ff  <= index_in;
         length_ff <= length_in;
         left_ff   <= left_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_byte_ff    <= s1_byte_ff;
         rsp_payload_ff <= rsp_payload_in;
         rsp_index_ff   <= rsp_index_in;
         rsp_length_ff  <= rsp_length_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_adone_ff   <= rsp_adone_in;
         rsp_cdone_ff   <= rsp_cdone_in;
         rsp_err_ff     <= rsp_err_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_value   = rsp_byte_ff;
   assign rsp_is_payload   = rsp_payload_ff;
   assign rsp_arg_index    = rsp_index_ff;
   assign rsp_arg_length   = rsp_length_ff;
   assign rsp_arg_count    = rsp_count_ff;
   assign rsp_arg_done     = rsp_adone_ff;
   assign rsp_command_done = rsp_cdone_ff;
   assign rsp_error_flag   = (rsp_err_ff != ERR_NONE);
   assign rsp_error_code   = rsp_err_ff;

   // a finished command or an error leaves the parser waiting for '*'
   a_restart: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (rsp_cdone_in || rsp_err_in != ERR_NONE) |=> phase_ff == PH_STAR)
      else $error("parser did not return to command start");

   a_cdone_adone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_done |-> rsp_arg_done && !rsp_is_payload &&
         !rsp_error_flag)
      else $error("command end without argument end");

   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_arg_count == 8'd0 &&
         rsp_arg_index == 8'd0 && !rsp_is_payload)
      else $error("error result carries argument context");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("stalled input stage lost its byte");

endmodule

`default_nettype wire

### tb/resp_request_parser_core_test.sv
// ----------------------------------------------------------------------------
// resp_request_parser_core_test: self-checking bench for the request parser
// Streams well-formed and broken array commands into the block one byte at a
// time, with random gaps and backpressure, and checks every response against
// a cycle-free shadow parser. Walks max_args through several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module resp_request_parser_core_test;
   import rrp_pkg::*;

   localparam logic [31:0] NUM_MAX = (32'd1 << DEF_LENGTH_BITS) - 32'd1;
   localparam logic [31:0] CNT_MAX = (32'd1 << DEF_COUNT_BITS) - 32'd1;
   localparam int PHASE_BYTES = 90;

   typedef struct packed {
      logic [7:0]                 byte_value;
      logic                       is_payload;
      logic [7:0]                 arg_index;
      logic [DEF_LENGTH_BITS-1:0] arg_length;
      logic [7:0]                 arg_count;
      logic                       arg_done;
      logic                       command_done;
      logic                       error_flag;
      logic [2:0]                 error_code;
   } parse_result_type;

   // Shadow parser: follows the framing byte by byte and queues the response
   // each request byte must produce.
   class parse_shadow_type;
      logic [7:0]       max_args;
      logic [3:0]       phase;
      logic [31:0]      accum;
      logic             digit_seen;
      logic [7:0]       count_held;
      logic [7:0]       index_held;
      logic [31:0]      length_held;
      logic [31:0]      bytes_left;
      parse_result_type results_due[$];
      int               errors;

      function new();
         errors = 0;
         max_args = MAX_ARGS_RESET;
         restart();
      endfunction

      function void restart();
         phase = PH_STAR;
         accum = 0;
         digit_seen = 1'b0;
         count_held = 0;
         index_held = 0;
         length_held = 0;
         bytes_left = 0;
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function logic [2:0] take_digit(logic [7:0] b, logic [3:0] lf_phase);
         logic [31:0] d;
         if (b == CHAR_CR) begin
            if (!digit_seen)
               return ERR_NO_DIGITS;
            phase = lf_phase;
            return ERR_NONE;
         end
         if (b < CHAR_ZERO || b > CHAR_NINE)
            return ERR_BAD_DIGIT;
         d = {24'd0, b - CHAR_ZERO};
         if (accum > NUM_MAX / 10 || (accum == NUM_MAX / 10 && d > NUM_MAX % 10))
            return ERR_OVERFLOW;
         accum = accum * 10 + d;
         digit_seen = 1'b1;
         return ERR_NONE;
      endfunction

      function void predict_byte(logic [7:0] b);
         parse_result_type r;
         logic [2:0]       err;
         r = '0;
         r.byte_value = b;
         r.arg_index = index_held;
         r.arg_length = length_held[DEF_LENGTH_BITS-1:0];
         r.arg_count = count_held;
         err = ERR_NONE;
         case (phase)
            PH_STAR: begin
               if (b == CHAR_STAR) begin
                  phase = PH_CNT_DIG;
                  accum = 0;
                  digit_seen = 1'b0;
               end else begin
                  err = ERR_BAD_PREFIX;
               end
            end
            PH_CNT_DIG: err = take_digit(b, PH_CNT_LF);
            PH_CNT_LF: begin
               if (b != CHAR_LF) begin
                  err = ERR_BAD_CRLF;
               end else if (accum < 1 || accum > {24'd0, max_args} || accum > CNT_MAX) begin
                  err = ERR_BAD_COUNT;
               end else begin
                  count_held = accum[7:0];
                  index_held = 0;
                  r.arg_count = count_held;
                  r.arg_index = 0;
                  phase = PH_DOLLAR;
               end
            end
            PH_DOLLAR: begin
               if (b == CHAR_DOLLAR) begin
                  length_held = 0;
                  r.arg_length = 0;
                  accum = 0;
                  digit_seen = 1'b0;
                  phase = PH_LEN_DIG;
               end else begin
                  err = ERR_BAD_PREFIX;
               end
            end
            PH_LEN_DIG: err = take_digit(b, PH_LEN_LF);
            PH_LEN_LF: begin
               if (b != CHAR_LF) begin
                  err = ERR_BAD_CRLF;
               end else begin
                  length_held = accum;
                  bytes_left = accum;
                  r.arg_length = accum[DEF_LENGTH_BITS-1:0];
                  phase = (bytes_left != 0) ? PH_PAYLOAD : PH_PAY_CR;
               end
            end
            PH_PAYLOAD: begin
               r.is_payload = 1'b1;
               if (bytes_left != 0)
                  bytes_left = bytes_left - 1;
               if (bytes_left == 0)
                  phase = PH_PAY_CR;
            end
            PH_PAY_CR: begin
               if (b == CHAR_CR)
                  phase = PH_PAY_LF;
               else
                  err = ERR_BAD_CRLF;
            end
            PH_PAY_LF: begin
               if (b != CHAR_LF) begin
                  err = ERR_BAD_CRLF;
               end else begin
                  r.arg_done = 1'b1;
                  index_held = index_held + 8'd1;
                  if (index_held >= count_held) begin
                     r.command_done = 1'b1;
                     restart();
                  end else begin
                     phase = PH_DOLLAR;
                  end
               end
            end
            default: restart();
         endcase
         // drop the partial command and zero the context fields
         if (err != ERR_NONE) begin
            restart();
            r.arg_index = 0;
            r.arg_length = 0;
            r.arg_count = 0;
            r.error_flag = 1'b1;
            r.error_code = err;
         end
         results_due.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want, logic [7:0] b);
         if (got !== want)
            report($sformatf("%s for byte %02h: got %0h, want %0h", name, b, got, want));
      endtask

      task check_byte_result(parse_result_type got);
         parse_result_type want;
         if (results_due.size() == 0) begin
            report($sformatf("response for byte %02h with nothing outstanding",
                             got.byte_value));
            return;
         end
         want = results_due.pop_front();
         compare_field("byte_value", got.byte_value, want.byte_value, want.byte_value);
         compare_field("is_payload", got.is_payload, want.is_payload, want.byte_value);
         compare_field("arg_index", got.arg_index, want.arg_index, want.byte_value);
         compare_field("arg_length", got.arg_length, want.arg_length, want.byte_value);
         compare_field("arg_count", got.arg_count, want.arg_count, want.byte_value);
         compare_field("arg_done", got.arg_done, want.arg_done, want.byte_value);
         compare_field("command_done", got.command_done, want.command_done,
                       want.byte_value);
         compare_field("error_flag", got.error_flag, want.error_flag, want.byte_value);
         compare_field("error_code", got.error_code, want.error_code, want.byte_value);
      endtask
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       csr_write_en = 1'b0;
   logic [7:0]                 csr_write_data = 8'd0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_in_byte = 8'd0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [7:0]                 rsp_byte_value;
   logic                       rsp_is_payload;
   logic [7:0]                 rsp_arg_index;
   logic [DEF_LENGTH_BITS-1:0] rsp_arg_length;
   logic [7:0]                 rsp_arg_count;
   logic                       rsp_arg_done;
   logic                       rsp_command_done;
   logic                       rsp_error_flag;
   logic [2:0]                 rsp_error_code;

   parse_result_type observed;
   parse_shadow_type board;
   logic [7:0]       frame_bytes[$];
   bit               quiet = 1'b0;
   int               rsp_hold = 0;
   int               phase_sent = 0;

   resp_request_parser_core uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_is_payload   (rsp_is_payload),
      .rsp_arg_index    (rsp_arg_index),
      .rsp_arg_length   (rsp_arg_length),
      .rsp_arg_count    (rsp_arg_count),
      .rsp_arg_done     (rsp_arg_done),
      .rsp_command_done (rsp_command_done),
      .rsp_error_flag   (rsp_error_flag),
      .rsp_error_code   (rsp_error_code)
   );

   assign observed = {rsp_byte_value, rsp_is_payload, rsp_arg_index, rsp_arg_length,
                      rsp_arg_count, rsp_arg_done, rsp_command_done, rsp_error_flag,
                      rsp_error_code};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   function automatic int draw_wait();
      return quiet ? 0 : int'($urandom_range(0, 15));
   endfunction

   // Response side: check each accepted response, then hold off for a drawn
   // number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_byte_result(observed);
            rsp_hold = draw_wait();
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.predict_byte(b);
      phase_sent++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i]);
      frame_bytes.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_max_args(logic [7:0] value);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.max_args = value;
   endtask

   function automatic void push_byte(logic [7:0] b);
      frame_bytes.push_back(b);
   endfunction

   function automatic void push_crlf();
      frame_bytes.push_back(CHAR_CR);
      frame_bytes.push_back(CHAR_LF);
   endfunction

   function automatic void push_text(string s);
      int i;
      for (i = 0; i < s.len(); i++)
         frame_bytes.push_back(s[i]);
   endfunction

   function automatic void push_number(int unsigned v, int zeros);
      int i;
      for (i = 0; i < zeros; i++)
         frame_bytes.push_back(CHAR_ZERO);
      push_text($sformatf("%0d", v));
   endfunction

   function automatic logic [7:0] pick_noise();
      case ($urandom_range(0, 4))
         0: return CHAR_STAR;
         1: return CHAR_DOLLAR;
         2: return CHAR_CR;
         3: return CHAR_LF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // open a length line inside a one-argument command, or stay on the count line
   function automatic void push_number_line_start(bit on_length);
      push_byte(CHAR_STAR);
      if (on_length) begin
         push_number(1, 0);
         push_crlf();
         push_byte(CHAR_DOLLAR);
      end
   endfunction

   function automatic void build_command();
      int unsigned n_args, len, top;
      int          k, j;
      top = (board.max_args < 3) ? board.max_args : 3;
      n_args = $urandom_range(1, top);
      if (board.max_args <= 6 && $urandom_range(0, 3) == 0)
         n_args = board.max_args;
      push_byte(CHAR_STAR);
      push_number(n_args, ($urandom_range(0, 4) == 0) ? 1 : 0);
      push_crlf();
      for (k = 0; k < n_args; k++) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
         push_byte(CHAR_DOLLAR);
         push_number(len, 0);
         push_crlf();
         for (j = 0; j < len; j++)
            push_byte(8'($urandom_range(0, 255)));
         push_crlf();
      end
   endfunction

   function automatic void build_malformed(int unsigned pick);
      bit          on_length;
      int unsigned d;
      logic [7:0]  b;
      on_length = $urandom_range(0, 1);
      if (pick < 73) begin
         // numbers at the top of the range
         push_number_line_start(on_length);
         push_text("214748364");
         d = $urandom_range(0, 9);
         push_byte(CHAR_ZERO + 8'(d));
         if (d <= 7) begin
            if ($urandom_range(0, 1) == 0) begin
               push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end else if (on_length) begin
               push_byte(CHAR_CR);
               push_byte(8'($urandom_range(11, 255)));
            end else begin
               push_crlf();
            end
         end
      end else if (pick < 81) begin
         push_byte(CHAR_STAR);
         if ($urandom_range(0, 3) == 0)
            push_number(0, $urandom_range(0, 1));
         else
            push_number($urandom_range(board.max_args + 1, 999), 0);
         push_crlf();
      end else if (pick < 89) begin
         push_number_line_start(on_length);
         push_byte(CHAR_CR);
      end else if (pick < 95) begin
         push_number_line_start(on_length);
         for (d = $urandom_range(0, 2); d > 0; d--)
            push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
         do
            b = 8'($urandom_range(0, 255));
         while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_CR);
         push_byte(b);
      end else begin
         for (d = $urandom_range(1, 3); d > 0; d--)
            push_byte(pick_noise());
      end
   endfunction

   task automatic run_random_phase();
      int unsigned pick, pos;
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            build_command();
            pos = $urandom_range(1, frame_bytes.size() - 1);
            case ($urandom_range(0, 9))
               0, 1: frame_bytes[pos] = pick_noise();
               2: while (frame_bytes.size() > pos) void'(frame_bytes.pop_back());
               default: ;
            endcase
         end else begin
            build_malformed(pick);
         end
         send_frame();
      end
   endtask

   initial begin
      logic [7:0] settings[5];
      int         p;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme bytes, every error kind but overflow and a zero-length argument
      push_byte(8'hFF);
      push_byte(CHAR_STAR);
      push_byte(CHAR_CR);
      push_byte(CHAR_STAR);
      push_number(0, 0);
      push_crlf();
      push_byte(CHAR_STAR);
      push_number(1, 0);
      push_crlf();
      push_byte(CHAR_DOLLAR);
      push_number(0, 0);
      push_crlf();
      push_crlf();
      push_byte(CHAR_STAR);
      push_number(1, 0);
      push_byte(8'h00);
      push_byte(CHAR_STAR);
      push_number(1, 0);
      push_byte(CHAR_CR);
      push_text("X");
      send_frame();

      settings[0] = 8'd1;
      settings[1] = 8'd255;
      settings[2] = 8'($urandom_range(2, 5));
      settings[3] = 8'($urandom_range(1, 255));
      settings[4] = MAX_ARGS_RESET;
      for (p = 0; p < 5; p++) begin
         write_max_args(settings[p]);
         quiet = (p == 2) || ($urandom_range(0, 4) == 0);
         run_random_phase();
      end

      drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
design/rrp_pkg.sv
design/resp_request_parser_core.sv
tb/resp_request_parser_core_test.sv
